// File: rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int ITEM_BITS_DEF = 32;
  localparam int CAPACITY_MAX  = 1024;

  // Width of index and step values handed along the cell row.
  localparam int SEL_W   = $clog2(CAPACITY_MAX + 1);

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_POP     = 3'd2,
    OP_GET     = 3'd3,
    OP_SET     = 3'd4,
    OP_REVERSE = 3'd5
  } op_t;

  // What every cell does with its entry.
  typedef enum logic [2:0] {
    ENT_HOLD,
    ENT_WRITE,
    ENT_INSERT,
    ENT_POP,
    ENT_REV
  } ent_cmd_t;

  // What every cell does with its read tap.
  typedef enum logic [1:0] {
    TAP_HOLD,
    TAP_LOAD,
    TAP_SHIFT
  } tap_cmd_t;

  typedef struct packed {
    ent_cmd_t         ent_cmd;
    tap_cmd_t         tap_cmd;
    logic [SEL_W-1:0] sel;
  } ctrl_t;

endpackage

// File: rtl/core/ile_cell.sv
// One list cell: a stored entry plus a read tap that shifts toward cell zero.
module ile_cell #(
  parameter int INDEX     = 0,
  parameter int ITEM_BITS = ile_pkg::ITEM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ile_pkg::ctrl_t       ctrl,
  input  logic [ITEM_BITS-1:0] item_in,
  input  logic [ITEM_BITS-1:0] left_val,
  input  logic [ITEM_BITS-1:0] right_val,
  input  logic [ITEM_BITS-1:0] head_val,
  input  logic [ITEM_BITS-1:0] right_tap,
  output logic [ITEM_BITS-1:0] val,
  output logic [ITEM_BITS-1:0] tap
);
  import ile_pkg::*;

  localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(INDEX);

  logic [ITEM_BITS-1:0] val_next;
  logic [ITEM_BITS-1:0] tap_next;

  always_comb begin
    val_next = val;
    unique case (ctrl.ent_cmd)
      ENT_HOLD: ;
      ENT_WRITE: begin
        if (MY_IDX == ctrl.sel) val_next = item_in;
      end
      ENT_INSERT: begin
        if (MY_IDX == ctrl.sel) val_next = item_in;
        else if (MY_IDX > ctrl.sel) val_next = left_val;
      end
      ENT_POP: begin
        if (MY_IDX >= ctrl.sel) val_next = right_val;
      end
      ENT_REV: begin
        // The head entry moves to the boundary; everything below it slides down.
        if (MY_IDX < ctrl.sel) val_next = right_val;
        else if (MY_IDX == ctrl.sel) val_next = head_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    tap_next = tap;
    unique case (ctrl.tap_cmd)
      TAP_HOLD:  ;
      TAP_LOAD:  tap_next = val;
      TAP_SHIFT: tap_next = right_tap;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      val <= val_next;
    end
  end

  always_ff @(posedge clk) begin
    tap <= tap_next;
  end

endmodule

// File: rtl/core/ile_seq.sv
// Sequencer that checks each request and steps the cell row through it.
module ile_seq #(
  parameter int CAPACITY  = ile_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = ile_pkg::ITEM_BITS_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ile_pkg::OP_W-1:0]  opcode,
  input  logic [ile_pkg::POS_W-1:0] position,
  input  logic [ITEM_BITS-1:0]      item_in,
  input  logic [ITEM_BITS-1:0]      head_val,
  input  logic [ITEM_BITS-1:0]      head_tap,
  output ile_pkg::ctrl_t            ctrl,
  output logic [ITEM_BITS-1:0]      item_q,
  output logic                      done,
  output logic [ITEM_BITS-1:0]      res_read,
  output logic [CNT_W-1:0]          res_count,
  output logic [ITEM_BITS-1:0]      res_first,
  output logic [ITEM_BITS-1:0]      res_last,
  output logic                      res_empty,
  output logic                      res_full,
  output logic                      res_bad
);
  import ile_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_EDIT,
    S_LOAD,
    S_LAST
  } state_t;

  state_t           state;
  op_t              op_q;
  logic [SEL_W-1:0] pos_q;
  logic [CNT_W-1:0] count;
  logic [SEL_W-1:0] cnt;
  logic [SEL_W-1:0] lim;
  logic             bad_q;
  logic             rd_en_q;
  logic [ITEM_BITS-1:0] rd_q;

  logic [SEL_W-1:0] pos_w;
  logic [SEL_W-1:0] cnt_w;
  logic             full;
  logic             req_bad;
  logic             req_read;
  op_t              req_op;

  assign pos_w  = SEL_W'(position);
  assign cnt_w  = SEL_W'(count);
  assign full   = (count == CNT_W'(CAPACITY));
  assign req_op = op_t'(opcode);
  assign busy   = (state != S_IDLE);

  always_comb begin
    req_bad  = 1'b0;
    req_read = 1'b0;
    unique case (req_op)
      OP_APPEND:  req_bad = full;
      OP_INSERT:  req_bad = full || (pos_w > cnt_w);
      OP_POP, OP_GET, OP_SET: begin
        req_bad  = (pos_w >= cnt_w);
        req_read = 1'b1;
      end
      OP_REVERSE: req_bad = 1'b0;
      default:    req_bad = 1'b1;
    endcase
  end

  always_comb begin
    ctrl.ent_cmd = ENT_HOLD;
    ctrl.tap_cmd = TAP_HOLD;
    ctrl.sel     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) ctrl.tap_cmd = TAP_LOAD;
      end
      S_SEEK: begin
        if (cnt != '0) ctrl.tap_cmd = TAP_SHIFT;
      end
      S_EDIT: begin
        if (!bad_q) begin
          unique case (op_q)
            OP_APPEND: begin
              ctrl.ent_cmd = ENT_WRITE;
              ctrl.sel     = cnt_w;
            end
            OP_INSERT: begin
              ctrl.ent_cmd = ENT_INSERT;
              ctrl.sel     = pos_q;
            end
            OP_POP: begin
              ctrl.ent_cmd = ENT_POP;
              ctrl.sel     = pos_q;
            end
            OP_SET: begin
              ctrl.ent_cmd = ENT_WRITE;
              ctrl.sel     = pos_q;
            end
            OP_REVERSE: begin
              if (lim != '0) begin
                ctrl.ent_cmd = ENT_REV;
                ctrl.sel     = lim;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: ctrl.tap_cmd = TAP_LOAD;
      S_LAST: begin
        if (cnt != '0) ctrl.tap_cmd = TAP_SHIFT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= req_op;
            pos_q   <= pos_w;
            item_q  <= item_in;
            bad_q   <= req_bad;
            rd_en_q <= req_read && !req_bad;
            cnt     <= (req_read && !req_bad) ? pos_w : '0;
            state   <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (cnt == '0) begin
            rd_q  <= rd_en_q ? head_tap : '0;
            lim   <= (count > CNT_W'(1)) ? cnt_w - SEL_W'(1) : '0;
            state <= S_EDIT;
          end else begin
            cnt <= cnt - SEL_W'(1);
          end
        end
        S_EDIT: begin
          if (op_q == OP_REVERSE) begin
            if (lim > SEL_W'(1)) begin
              lim <= lim - SEL_W'(1);
            end else begin
              state <= S_LOAD;
            end
          end else begin
            if (!bad_q) begin
              if (op_q == OP_APPEND || op_q == OP_INSERT) count <= count + CNT_W'(1);
              else if (op_q == OP_POP) count <= count - CNT_W'(1);
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt   <= (count == '0) ? '0 : cnt_w - SEL_W'(1);
          state <= S_LAST;
        end
        S_LAST: begin
          if (cnt == '0) begin
            res_read  <= rd_q;
            res_count <= count;
            res_first <= head_val;
            res_last  <= head_tap;
            res_empty <= (count == '0);
            res_full  <= full;
            res_bad   <= bad_q;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            cnt <= cnt - SEL_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_SEEK))
    else $error("accepted item did not start the read phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDIT && !bad_q) |=> (count <= CNT_W'(CAPACITY)))
    else $error("live count exceeds capacity");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDIT && bad_q) |=> $stable(count))
    else $error("refused request changed the live count");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("one item produced two results");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (res_empty == (res_count == '0)))
    else $error("empty flag disagrees with reported count");

endmodule

// File: rtl/core/indexed_list_engine_top.sv
// Top level of the indexed list engine: a row of list cells under one sequencer.
// An item passes the seek, edit, load and last states. Seek shifts the read taps until
// cell zero shows the entry read by a pop, get or set; edit repeats for a reverse of
// three or more entries; last shifts the taps until cell zero shows the last entry.
// Throughput: one item at a time; busy holds until the strobe; the receiver cannot stall.
// Reset (rst, synchronous, active high) empties the list and clears every stored entry.
module indexed_list_engine_top #(
  parameter int CAPACITY  = ile_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = ile_pkg::ITEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ile_pkg::OP_W-1:0]    opcode,
  input  logic [ile_pkg::POS_W-1:0]   position,
  input  logic [ile_pkg::WORD_W-1:0]  new_item,
  output logic                        done,
  output logic [ile_pkg::WORD_W-1:0]  read_item,
  output logic [ile_pkg::COUNT_W-1:0] count,
  output logic [ile_pkg::WORD_W-1:0]  first_item,
  output logic [ile_pkg::WORD_W-1:0]  last_item,
  output logic                        is_empty,
  output logic                        is_full,
  output logic                        bad_request
);
  import ile_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The live entries sit in cells 0 .. count-1; every cell above holds zero.
  // All cells see the same control word and pick their own action from
  // their index, so an insert, pop, append or set is applied across the whole row at once.

  ctrl_t                ctrl;
  logic [ITEM_BITS-1:0] item_in;
  logic [ITEM_BITS-1:0] item_q;
  logic [ITEM_BITS-1:0] val [CAPACITY];
  logic [ITEM_BITS-1:0] tap [CAPACITY];

  logic [ITEM_BITS-1:0] res_read;
  logic [CNT_W-1:0]     res_count;
  logic [ITEM_BITS-1:0] res_first;
  logic [ITEM_BITS-1:0] res_last;

  logic [63:0] new_wide;
  logic [63:0] read_wide;
  logic [63:0] first_wide;
  logic [63:0] last_wide;

  // Only the low ITEM_BITS bits of an incoming item are stored.
  assign new_wide = 64'(new_item);
  assign item_in  = new_wide[ITEM_BITS-1:0];

  ile_seq #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .position  (position),
    .item_in   (item_in),
    .head_val  (val[0]),
    .head_tap  (tap[0]),
    .ctrl      (ctrl),
    .item_q    (item_q),
    .done      (done),
    .res_read  (res_read),
    .res_count (res_count),
    .res_first (res_first),
    .res_last  (res_last),
    .res_empty (is_empty),
    .res_full  (is_full),
    .res_bad   (bad_request)
  );

  // Each cell hands its entry to both neighbors and its tap to the cell
  // below. The row ends feed zero, which is what a pop leaves in the top cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] left_val;
    logic [ITEM_BITS-1:0] right_val;
    logic [ITEM_BITS-1:0] right_tap;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_tap = '0;
    end else begin : g_inner_r
      assign right_val = val[i+1];
      assign right_tap = tap[i+1];
    end

    ile_cell #(
      .INDEX     (i),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .item_in   (item_q),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (val[0]),
      .right_tap (right_tap),
      .val       (val[i]),
      .tap       (tap[i])
    );
  end

  // Results are widened or cut to the fixed port width.
  assign read_wide  = 64'(res_read);
  assign first_wide = 64'(res_first);
  assign last_wide  = 64'(res_last);
  assign read_item  = read_wide[WORD_W-1:0];
  assign first_item = first_wide[WORD_W-1:0];
  assign last_item  = last_wide[WORD_W-1:0];
  assign count      = COUNT_W'(res_count);

endmodule

// File: sim/indexed_list_checker.sv
// Checker for the indexed list engine: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module indexed_list_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [ile_pkg::OP_W-1:0]    opcode,
  input  logic [ile_pkg::POS_W-1:0]   position,
  input  logic [ile_pkg::WORD_W-1:0]  new_item,
  input  logic                        done,
  input  logic [ile_pkg::WORD_W-1:0]  read_item,
  input  logic [ile_pkg::COUNT_W-1:0] count,
  input  logic [ile_pkg::WORD_W-1:0]  first_item,
  input  logic [ile_pkg::WORD_W-1:0]  last_item,
  input  logic                        is_empty,
  input  logic                        is_full,
  input  logic                        bad_request,
  output int                          fail_count,
  output int                          pending
);
  import ile_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic [WORD_W-1:0]  read_item;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  first_item;
    logic [WORD_W-1:0]  last_item;
    logic               is_empty;
    logic               is_full;
    logic               bad_request;
  } list_result_t;

  // Shadow copy of the list; cells at and above list_len stay zero.
  logic [WORD_W-1:0] cells [CAP];
  int                list_len;
  list_result_t      expected_results [$];
  int                errors;

  // Applies one operation to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                 logic [WORD_W-1:0] item);
    list_result_t      res;
    logic [WORD_W-1:0] swap;
    int                p;
    int                lo;
    int                hi;
    p = int'(pos);
    res = '0;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAP) begin
          res.bad_request = 1'b1;
        end else begin
          cells[list_len] = item;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (list_len >= CAP || p > list_len) begin
          res.bad_request = 1'b1;
        end else begin
          for (int i = list_len; i > p; i--) cells[i] = cells[i-1];
          cells[p] = item;
          list_len++;
        end
      end
      OP_POP: begin
        if (p >= list_len) begin
          res.bad_request = 1'b1;
        end else begin
          res.read_item = cells[p];
          for (int i = p + 1; i < list_len; i++) cells[i-1] = cells[i];
          cells[list_len-1] = '0;
          list_len--;
        end
      end
      OP_GET: begin
        if (p >= list_len) res.bad_request = 1'b1;
        else res.read_item = cells[p];
      end
      OP_SET: begin
        if (p >= list_len) begin
          res.bad_request = 1'b1;
        end else begin
          res.read_item = cells[p];
          cells[p] = item;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (hi > lo) begin
          swap      = cells[lo];
          cells[lo] = cells[hi];
          cells[hi] = swap;
          lo++;
          hi--;
        end
      end
      default: res.bad_request = 1'b1;
    endcase
    res.count      = COUNT_W'(list_len);
    res.first_item = (list_len > 0) ? cells[0] : '0;
    res.last_item  = (list_len > 0) ? cells[list_len-1] : '0;
    res.is_empty   = (list_len == 0);
    res.is_full    = (list_len == CAP);
    return res;
  endfunction

  task automatic compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      for (int i = 0; i < CAP; i++) cells[i] = '0;
      list_len = 0;
      expected_results.delete();
      errors = 0;
    end else begin
      // The older item's result is compared before a new item is queued behind it.
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result strobe with no item outstanding", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_item", want.read_item, read_item);
          compare_field("count", WORD_W'(want.count), WORD_W'(count));
          compare_field("first_item", want.first_item, first_item);
          compare_field("last_item", want.last_item, last_item);
          compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(is_empty));
          compare_field("is_full", WORD_W'(want.is_full), WORD_W'(is_full));
          compare_field("bad_request", WORD_W'(want.bad_request), WORD_W'(bad_request));
        end
      end
      if (start && !busy) expected_results.push_back(apply_list_op(opcode, position, new_item));
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

// File: sim/indexed_list_engine_top_tb.sv
// Testbench top for the indexed list engine: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module indexed_list_engine_top_tb;
  import ile_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1625;
  // The limit is many times the slowest item plus a sender gap.
  localparam int LIMIT_CYCLES = 1_500_000;
  // Quiet time after the last result, longer than the slowest item.
  localparam int DRAIN_CYCLES = 300;

  // Opcodes the block does not define; it must refuse them.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Stimulus flavors: grow the list toward full, shrink it toward empty, or a mix that grows.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     opcode;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   new_item;
  logic                done;
  logic [WORD_W-1:0]   read_item;
  logic [COUNT_W-1:0]  count;
  logic [WORD_W-1:0]   first_item;
  logic [WORD_W-1:0]   last_item;
  logic                is_empty;
  logic                is_full;
  logic                bad_request;
  int                  fail_count;
  int                  pending;
  int                  cycles;

  // Length the list will have once every accepted item has been applied. It only steers
  // the choice of positions; the checker does the real prediction.
  int                  len_est;
  int                  burst_left;

  indexed_list_engine_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .position    (position),
    .new_item    (new_item),
    .done        (done),
    .read_item   (read_item),
    .count       (count),
    .first_item  (first_item),
    .last_item   (last_item),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .bad_request (bad_request)
  );

  indexed_list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .position    (position),
    .new_item    (new_item),
    .done        (done),
    .read_item   (read_item),
    .count       (count),
    .first_item  (first_item),
    .last_item   (last_item),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .bad_request (bad_request),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or stops answering.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Tracks only the length change of an item; refused items leave it alone.
  function automatic int length_after(logic [OP_W-1:0] op, int pos, int len);
    case (op)
      OP_APPEND: return (len < CAP) ? len + 1 : len;
      OP_INSERT: return (len < CAP && pos <= len) ? len + 1 : len;
      OP_POP:    return (pos < len) ? len - 1 : len;
      default:   return len;
    endcase
  endfunction

  // Weighted opcode choice. A small share of the undefined opcodes is always mixed in.
  function automatic logic [OP_W-1:0] pick_op(int mode);
    int roll;
    int w_app;
    int w_ins;
    int w_pop;
    int w_get;
    int w_set;
    roll = $urandom_range(99, 0);
    case (mode)
      MODE_FILL: begin
        w_app = 35; w_ins = 30; w_pop = 8;  w_get = 10; w_set = 10;
      end
      MODE_DRAIN: begin
        w_app = 8;  w_ins = 8;  w_pop = 50; w_get = 12; w_set = 12;
      end
      default: begin
        w_app = 18; w_ins = 18; w_pop = 20; w_get = 17; w_set = 15;
      end
    endcase
    if (roll < w_app) return OP_APPEND;
    roll -= w_app;
    if (roll < w_ins) return OP_INSERT;
    roll -= w_ins;
    if (roll < w_pop) return OP_POP;
    roll -= w_pop;
    if (roll < w_get) return OP_GET;
    roll -= w_get;
    if (roll < w_set) return OP_SET;
    roll -= w_set;
    if (roll >= 2) return OP_REVERSE;
    return $urandom_range(1, 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
  endfunction

  // Most positions land inside the live range so that the item does real work; the rest
  // are drawn from the whole field and mostly get refused.
  function automatic logic [POS_W-1:0] pick_pos(logic [OP_W-1:0] op, int len);
    if ($urandom_range(99, 0) < 15) return POS_W'($urandom_range(63, 0));
    case (op)
      OP_INSERT: return POS_W'($urandom_range((len > 63) ? 63 : len, 0));
      OP_POP, OP_GET, OP_SET: begin
        if (len == 0) return POS_W'($urandom_range(63, 0));
        return POS_W'($urandom_range(len - 1, 0));
      end
      default: return POS_W'($urandom_range(63, 0));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_item();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return WORD_W'($urandom);
  endfunction

  // Presents one item and holds it until the block takes it. At the end of a burst the
  // sender drops start for a random gap, which lands while the block is still working.
  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] item);
    start    <= 1'b1;
    opcode   <= op;
    position <= pos;
    new_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    len_est = length_after(op, int'(pos), len_est);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = $urandom_range(40, 1);
    end
  endtask

  // Stops sending until every outstanding result has come back. The first edge lets the
  // checker register the item that was just accepted.
  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_items(int mode, int num);
    logic [OP_W-1:0] op;
    for (int n = 0; n < num; n++) begin
      op = pick_op(mode);
      send_item(op, pick_pos(op, len_est), pick_item());
    end
  endtask

  initial begin
    int sent;
    int seg_len;
    rst        <= 1'b1;
    start      <= 1'b0;
    opcode     <= OP_APPEND;
    position   <= '0;
    new_item   <= '0;
    len_est    = 0;
    burst_left = $urandom_range(40, 1);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Everything touching an empty list must be refused, except reverse,
    // which simply does nothing; the undefined opcodes are refused too.
    send_item(OP_POP, 6'd0, 32'h1111_1111);
    send_item(OP_GET, 6'd0, '0);
    send_item(OP_SET, 6'd0, 32'h2222_2222);
    send_item(OP_REVERSE, 6'd63, '1);
    send_item(OP_UNUSED_LO, 6'd0, 32'h3333_3333);
    send_item(OP_UNUSED_HI, 6'd63, '1);
    // Insert past the end is refused; insert at the end behaves as an append.
    send_item(OP_INSERT, 6'd1, 32'h4444_4444);
    send_item(OP_INSERT, 6'd0, '1);
    // Reverse of a single entry leaves it alone; of two entries it swaps them.
    send_item(OP_REVERSE, 6'd0, '0);
    send_item(OP_APPEND, 6'd0, '0);
    send_item(OP_REVERSE, 6'd0, '0);
    send_item(OP_APPEND, 6'd42, 32'h1234_5678);
    send_item(OP_INSERT, 6'd1, 32'hA5A5_A5A5);
    send_item(OP_INSERT, 6'd4, 32'h5A5A_5A5A);
    send_item(OP_GET, 6'd4, '0);
    send_item(OP_GET, 6'd5, '0);
    send_item(OP_SET, 6'd0, 32'hDEAD_BEEF);
    send_item(OP_SET, 6'd63, 32'hFFFF_0000);
    send_item(OP_POP, 6'd2, '0);
    send_item(OP_POP, 6'd3, '0);
    send_item(OP_REVERSE, 6'd0, '0);
    send_item(OP_POP, 6'd0, '0);
    wait_all_results();

    // Random part. The first segment fills the list so that appends and inserts on a full
    // list are refused early; later segments wander between full and empty, sometimes
    // letting the block run dry before going on.
    send_random_items(MODE_FILL, 150);
    sent = 150;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(200, 60);
      if (seg_len > RANDOM_ITEMS - sent) seg_len = RANDOM_ITEMS - sent;
      send_random_items($urandom_range(MODE_MIXED, MODE_FILL), seg_len);
      sent += seg_len;
      if ($urandom_range(2, 0) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/ile_seq.sv
rtl/core/indexed_list_engine_top.sv
sim/indexed_list_checker.sv
sim/indexed_list_engine_top_tb.sv
